@@ design/tasmg_pkg.sv @@
`timescale 1ns / 1ps

package tasmg_pkg;

  localparam int FRAC_BITS   = 8;
  localparam int COUNT_WIDTH = 16;
  localparam int TARGET_W    = 16;
  localparam int POS_W       = TARGET_W + FRAC_BITS;
  localparam int REG_W       = 16;
  localparam int CNT_W       = $clog2(POS_W);
  localparam int SUM_W       = POS_W + COUNT_WIDTH + REG_W;

  localparam logic [REG_W-1:0] STEP_DIST_RESET    = REG_W'(461);
  localparam logic [REG_W-1:0] PULSE_HIGH_RESET   = REG_W'(160);
  localparam logic [REG_W-1:0] PULSE_PERIOD_RESET = REG_W'(6400);

  localparam logic [1:0] REG_STEP_DIST    = 2'd0;
  localparam logic [1:0] REG_PULSE_HIGH   = 2'd1;
  localparam logic [1:0] REG_PULSE_PERIOD = 2'd2;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_MOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic instant;
    logic move_start;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
    logic div_last;
  } status_t;

endpackage

@@ design/tasmg_ctrl.sv @@
`timescale 1ns / 1ps

module tasmg_ctrl import tasmg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    func,
  input  status_t status,
  output logic    in_ready,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && func == FUNC_MOVE && !status.busy) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (status.div_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.instant    = 1'b0;
    cmd.move_start = 1'b0;
    cmd.div_step   = 1'b0;
    cmd.finish     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready       = status.out_free;
        cmd.move_start = accept && func == FUNC_MOVE && !status.busy;
        cmd.instant    = accept && !(func == FUNC_MOVE && !status.busy);
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ design/tasmg_dp.sv @@
`timescale 1ns / 1ps

module tasmg_dp import tasmg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [REG_W-1:0]       cfg_data,
  input  logic                   func,
  input  logic                   axis,
  input  logic [TARGET_W-1:0]    target,
  input  logic                   out_ready,
  input  cmd_t                   cmd,
  output status_t                status,
  output logic                   out_valid,
  output logic                   step_x,
  output logic                   step_y,
  output logic                   dir_x,
  output logic                   dir_y,
  output logic                   busy_res,
  output logic                   accepted,
  output logic [COUNT_WIDTH-1:0] pulse_count,
  output logic [POS_W-1:0]       new_position
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [REG_W-1:0]       step_dist;
  logic [REG_W-1:0]       pulse_high_ticks;
  logic [REG_W-1:0]       pulse_period_ticks;

  logic [POS_W-1:0]       position_x;
  logic [POS_W-1:0]       position_y;
  logic                   direction_x;
  logic                   direction_y;
  logic [COUNT_WIDTH-1:0] pulses_left;
  logic                   moving_axis;
  logic [REG_W-1:0]       period_count;

  logic                   mv_axis;
  logic                   mv_dir;
  logic [POS_W-1:0]       mv_mag;
  logic [POS_W-1:0]       mv_pos;
  logic [REG_W-1:0]       mv_dist;
  logic [POS_W-1:0]       quo;
  logic [REG_W-1:0]       rem;
  logic [CNT_W-1:0]       cnt;

  logic [REG_W-1:0]       period_eff;
  logic [REG_W-1:0]       period_count_inc;
  logic                   pulse_done;
  logic                   tick_level;
  logic                   tick_active;
  logic [COUNT_WIDTH-1:0] pulses_left_tick;
  logic [REG_W-1:0]       period_count_tick;

  logic [POS_W-1:0]       tq;
  logic [POS_W-1:0]       pos_sel;
  logic                   dir_new;
  logic [POS_W-1:0]       mag_new;

  logic [REG_W:0]         trial;
  logic                   trial_ge;

  logic                   sat;
  logic [COUNT_WIDTH-1:0] pulses_fin;
  logic [SUM_W-1:0]       sat_moved;
  logic [POS_W-1:0]       moved;
  logic [POS_W-1:0]       pos_fin;

  assign period_eff        = (pulse_period_ticks == '0) ? REG_W'(1) : pulse_period_ticks;
  assign period_count_inc  = period_count + REG_W'(1);
  assign pulse_done        = period_count_inc >= period_eff;
  assign tick_active       = func == FUNC_TICK && pulses_left != '0;
  assign tick_level        = tick_active && (period_count < pulse_high_ticks);
  assign pulses_left_tick  = pulse_done ? pulses_left - COUNT_WIDTH'(1) : pulses_left;
  assign period_count_tick = pulse_done ? '0 : period_count_inc;

  assign tq      = {target, {FRAC_BITS{1'b0}}};
  assign pos_sel = axis ? position_y : position_x;
  assign dir_new = !(tq > pos_sel);
  assign mag_new = dir_new ? pos_sel - tq : tq - pos_sel;

  assign trial    = {rem, quo[POS_W-1]};
  assign trial_ge = trial >= {1'b0, mv_dist};

  assign sat        = SUM_W'(quo) > SUM_W'(COUNT_MAX);
  assign pulses_fin = sat ? COUNT_MAX : COUNT_WIDTH'(quo);
  assign sat_moved  = (SUM_W'(mv_dist) << COUNT_WIDTH) - SUM_W'(mv_dist);
  assign moved      = sat ? POS_W'(sat_moved) : mv_mag - POS_W'(rem);
  assign pos_fin    = mv_dir ? mv_pos - moved : mv_pos + moved;

  assign status.busy     = pulses_left != '0;
  assign status.out_free = !out_valid || out_ready;
  assign status.div_last = cnt == CNT_W'(POS_W - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_dist          <= STEP_DIST_RESET;
      pulse_high_ticks   <= PULSE_HIGH_RESET;
      pulse_period_ticks <= PULSE_PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_DIST:    step_dist          <= cfg_data;
        REG_PULSE_HIGH:   pulse_high_ticks   <= cfg_data;
        REG_PULSE_PERIOD: pulse_period_ticks <= cfg_data;
        default:          step_dist          <= step_dist;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_x   <= '0;
      position_y   <= '0;
      direction_x  <= 1'b0;
      direction_y  <= 1'b0;
      pulses_left  <= '0;
      moving_axis  <= 1'b0;
      period_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.instant && tick_active) begin
        pulses_left  <= pulses_left_tick;
        period_count <= period_count_tick;
      end
      if (cmd.finish) begin
        if (mv_axis) begin
          position_y  <= pos_fin;
          direction_y <= mv_dir;
        end else begin
          position_x  <= pos_fin;
          direction_x <= mv_dir;
        end
        moving_axis  <= mv_axis;
        pulses_left  <= pulses_fin;
        period_count <= '0;
      end
      if (cmd.instant || cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.move_start) begin
      mv_axis <= axis;
      mv_dir  <= dir_new;
      mv_mag  <= mag_new;
      mv_pos  <= pos_sel;
      mv_dist <= (step_dist == '0) ? REG_W'(1) : step_dist;
      quo     <= mag_new;
      rem     <= '0;
      cnt     <= '0;
    end else if (cmd.div_step) begin
      rem <= trial_ge ? REG_W'(trial - {1'b0, mv_dist}) : REG_W'(trial);
      quo <= {quo[POS_W-2:0], trial_ge};
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.instant) begin
      step_x       <= tick_level && !moving_axis;
      step_y       <= tick_level && moving_axis;
      dir_x        <= direction_x;
      dir_y        <= direction_y;
      busy_res     <= tick_active ? (pulses_left_tick != '0) : (pulses_left != '0);
      accepted     <= 1'b0;
      pulse_count  <= '0;
      new_position <= '0;
    end else if (cmd.finish) begin
      step_x       <= 1'b0;
      step_y       <= 1'b0;
      dir_x        <= mv_axis ? direction_x : mv_dir;
      dir_y        <= mv_axis ? mv_dir : direction_y;
      busy_res     <= pulses_fin != '0;
      accepted     <= 1'b1;
      pulse_count  <= pulses_fin;
      new_position <= pos_fin;
    end
  end

endmodule

@@ design/two_axis_stepper_move_generator.sv @@
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// in        in_valid / in_ready    func, axis, target
// out       out_valid / out_ready  step_x, step_y, dir_x, dir_y, busy_res, accepted,
//                                  pulse_count, new_position
// cfg       cfg_we                 cfg_index, cfg_data
//
// A tick or a refused move has its result registered in the cycle after the transfer.
// An accepted move is loaded, then divided by the bit-serial divider over all 24 quotient bits, then finished.
// Reset clears positions, directions, pulse state and loads the register defaults.
// A result waiting on out_ready holds the block; input is taken again once the result can move.

module two_axis_stepper_move_generator import tasmg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [REG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   func,
  input  logic                   axis,
  input  logic [TARGET_W-1:0]    target,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   step_x,
  output logic                   step_y,
  output logic                   dir_x,
  output logic                   dir_y,
  output logic                   busy_res,
  output logic                   accepted,
  output logic [COUNT_WIDTH-1:0] pulse_count,
  output logic [POS_W-1:0]       new_position
);

  cmd_t    cmd;
  status_t status;

  tasmg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  tasmg_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .func         (func),
    .axis         (axis),
    .target       (target),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .step_x       (step_x),
    .step_y       (step_y),
    .dir_x        (dir_x),
    .dir_y        (dir_y),
    .busy_res     (busy_res),
    .accepted     (accepted),
    .pulse_count  (pulse_count),
    .new_position (new_position)
  );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import tasmg_pkg::*;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  typedef struct packed {
    logic                   step_x;
    logic                   step_y;
    logic                   dir_x;
    logic                   dir_y;
    logic                   busy;
    logic                   taken;
    logic [COUNT_WIDTH-1:0] pulses;
    logic [POS_W-1:0]       pos;
  } stepper_res_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_ITEM,
    ROW_DRAIN
  } row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [1:0]          reg_idx;
    logic [REG_W-1:0]    reg_val;
    logic                fn;
    logic                ax;
    logic [TARGET_W-1:0] tgt;
    logic                typed;
    stepper_res_t        want;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [1:0]             cfg_index;
  logic [REG_W-1:0]       cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic                   func;
  logic                   axis;
  logic [TARGET_W-1:0]    target;
  logic                   out_valid;
  logic                   out_ready;
  logic                   step_x;
  logic                   step_y;
  logic                   dir_x;
  logic                   dir_y;
  logic                   busy_res;
  logic                   accepted;
  logic [COUNT_WIDTH-1:0] pulse_count;
  logic [POS_W-1:0]       new_position;

  two_axis_stepper_move_generator i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .axis         (axis),
    .target       (target),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .step_x       (step_x),
    .step_y       (step_y),
    .dir_x        (dir_x),
    .dir_y        (dir_y),
    .busy_res     (busy_res),
    .accepted     (accepted),
    .pulse_count  (pulse_count),
    .new_position (new_position)
  );

  // axis state mirror
  logic [REG_W-1:0]       m_step_dist;
  logic [REG_W-1:0]       m_high;
  logic [REG_W-1:0]       m_period;
  logic [POS_W-1:0]       m_pos [2];
  logic                   m_dir [2];
  logic [COUNT_WIDTH-1:0] m_pulses_owed;
  logic                   m_pulse_axis;
  logic [15:0]            m_phase;

  stepper_res_t expected_results [$];

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int n_errors     = 0;
  int n_checked    = 0;
  int n_items      = 0;
  int n_taken      = 0;
  int n_refused    = 0;
  int n_step_high  = 0;

  logic [REG_W-1:0] plan_step_dist [6] = '{16'd700, 16'd65535, 16'd256, 16'd3000, 16'd90,
                                           16'd1234};
  logic [REG_W-1:0] plan_high [6]      = '{16'd2, 16'd1, 16'd65535, 16'd3, 16'd4, 16'd2};
  logic [REG_W-1:0] plan_period [6]    = '{16'd5, 16'd1, 16'd2, 16'd7, 16'd3, 16'd4};

  stim_row_t opening_rows [] = '{
    '{ROW_ITEM, 2'd0, 16'd0, FUNC_TICK, AXIS_X, 16'h0000, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 24'd0}},
    '{ROW_ITEM, 2'd0, 16'd0, FUNC_MOVE, AXIS_X, 16'h0000, 1'b1,
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 16'd0, 24'd0}},
    '{ROW_ITEM, 2'd0, 16'd0, FUNC_MOVE, AXIS_Y, 16'h0000, 1'b1,
      '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 16'd0, 24'd0}},
    '{ROW_ITEM, 2'd0, 16'd0, FUNC_TICK, AXIS_Y, 16'hFFFF, 1'b1,
      '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0, 24'd0}},
    '{ROW_CFG, REG_PULSE_PERIOD, 16'd0, FUNC_TICK, AXIS_X, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 16'd0, FUNC_MOVE, AXIS_X, 16'h0002, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 16'd1, 24'd461}},
    '{ROW_ITEM, 2'd0, 16'd0, FUNC_MOVE, AXIS_Y, 16'hFFFF, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'd0, 24'd0}},
    '{ROW_ITEM, 2'd0, 16'd0, FUNC_TICK, AXIS_X, 16'h0000, 1'b1,
      '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 24'd0}},
    '{ROW_CFG, REG_STEP_DIST, 16'd0, FUNC_TICK, AXIS_X, 16'h0000, 1'b0, '0},
    '{ROW_CFG, REG_PULSE_HIGH, 16'd0, FUNC_TICK, AXIS_X, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 16'd0, FUNC_MOVE, AXIS_X, 16'h0002, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 16'd51, 24'd512}},
    '{ROW_ITEM, 2'd0, 16'd0, FUNC_TICK, AXIS_Y, 16'h5A5A, 1'b0, '0},
    '{ROW_DRAIN, 2'd0, 16'd0, FUNC_TICK, AXIS_X, 16'h0000, 1'b0, '0},
    '{ROW_CFG, REG_STEP_DIST, 16'hFFFF, FUNC_TICK, AXIS_X, 16'h0000, 1'b0, '0},
    '{ROW_CFG, REG_PULSE_HIGH, 16'hFFFF, FUNC_TICK, AXIS_X, 16'h0000, 1'b0, '0},
    '{ROW_CFG, REG_PULSE_PERIOD, 16'hFFFF, FUNC_TICK, AXIS_X, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 16'd0, FUNC_MOVE, AXIS_X, 16'h0000, 1'b1,
      '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 16'd0, 24'd512}},
    '{ROW_CFG, REG_PULSE_PERIOD, 16'd2, FUNC_TICK, AXIS_X, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 16'd0, FUNC_MOVE, AXIS_Y, 16'h0100, 1'b1,
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 16'd1, 24'h00FFFF}},
    '{ROW_ITEM, 2'd0, 16'd0, FUNC_TICK, AXIS_X, 16'hA5A5, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 16'd0, FUNC_TICK, AXIS_X, 16'h0000, 1'b1,
      '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 24'd0}},
    '{ROW_ITEM, 2'd0, 16'd0, FUNC_MOVE, AXIS_Y, 16'h0100, 1'b0, '0}
  };

  stim_row_t closing_rows [] = '{
    '{ROW_CFG, REG_STEP_DIST, 16'hFFFF, FUNC_TICK, AXIS_X, 16'h0000, 1'b0, '0},
    '{ROW_CFG, REG_PULSE_HIGH, 16'd3, FUNC_TICK, AXIS_X, 16'h0000, 1'b0, '0},
    '{ROW_CFG, REG_PULSE_PERIOD, 16'd1, FUNC_TICK, AXIS_X, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 16'd0, FUNC_MOVE, AXIS_X, 16'h0000, 1'b0, '0},
    '{ROW_DRAIN, 2'd0, 16'd0, FUNC_TICK, AXIS_X, 16'h0000, 1'b0, '0},
    '{ROW_CFG, REG_STEP_DIST, 16'd0, FUNC_TICK, AXIS_X, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 16'd0, FUNC_MOVE, AXIS_X, 16'hFFFF, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 16'd0, FUNC_TICK, AXIS_Y, 16'h0000, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 16'd0, FUNC_TICK, AXIS_X, 16'hFFFF, 1'b0, '0},
    '{ROW_ITEM, 2'd0, 16'd0, FUNC_MOVE, AXIS_Y, 16'h1234, 1'b0, '0}
  };

  function automatic stepper_res_t predict_axis_result(input logic fn, input logic ax,
                                                       input logic [TARGET_W-1:0] tgt);
    stepper_res_t     r;
    logic [REG_W-1:0] period_eff;
    logic [REG_W-1:0] step_len;
    logic [POS_W-1:0] tq;
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] mag;
    logic [31:0]      q;
    logic             d;
    r = '0;
    if (fn == FUNC_TICK) begin
      if (m_pulses_owed != 0) begin
        period_eff = (m_period == 0) ? 16'd1 : m_period;
        if (m_pulse_axis == AXIS_X) r.step_x = (m_phase < m_high);
        else r.step_y = (m_phase < m_high);
        m_phase = m_phase + 16'd1;
        if (m_phase >= period_eff) begin
          m_phase = '0;
          m_pulses_owed = m_pulses_owed - COUNT_WIDTH'(1);
        end
      end
    end else if (m_pulses_owed == 0) begin
      p = m_pos[ax];
      tq = {tgt, {FRAC_BITS{1'b0}}};
      step_len = (m_step_dist == 0) ? 16'd1 : m_step_dist;
      d = !(tq > p);
      mag = d ? p - tq : tq - p;
      q = 32'(mag) / 32'(step_len);
      if (q > 32'hFFFF) q = 32'hFFFF;
      if (d) p = p - POS_W'(q * 32'(step_len));
      else p = p + POS_W'(q * 32'(step_len));
      m_pos[ax] = p;
      m_dir[ax] = d;
      m_pulse_axis = ax;
      m_pulses_owed = q[COUNT_WIDTH-1:0];
      m_phase = '0;
      r.taken = 1'b1;
      r.pulses = q[COUNT_WIDTH-1:0];
      r.pos = p;
    end
    r.dir_x = m_dir[AXIS_X];
    r.dir_y = m_dir[AXIS_Y];
    r.busy = (m_pulses_owed != 0);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  task automatic send_item(input logic fn, input logic ax, input logic [TARGET_W-1:0] tgt,
                           input logic typed, input stepper_res_t want);
    stepper_res_t r;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    func = fn;
    axis = ax;
    target = tgt;
    do @(posedge clk); while (!in_ready);
    r = predict_axis_result(fn, ax, tgt);
    expected_results.push_back(typed ? want : r);
    n_items++;
    if (r.taken) n_taken++;
    else if (fn == FUNC_MOVE) n_refused++;
    if (r.step_x || r.step_y) n_step_high++;
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [REG_W-1:0] val);
    hold_until_drained();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_STEP_DIST:    m_step_dist = val;
      REG_PULSE_HIGH:   m_high = val;
      REG_PULSE_PERIOD: m_period = val;
      default: ;
    endcase
  endtask

  task automatic drain_pulses();
    while (m_pulses_owed != 0) send_item(FUNC_TICK, 1'($urandom), 16'($urandom), 1'b0, '0);
  endtask

  task automatic play_rows(input stim_row_t rows []);
    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_CFG:   write_reg(rows[i].reg_idx, rows[i].reg_val);
        ROW_ITEM:  send_item(rows[i].fn, rows[i].ax, rows[i].tgt, rows[i].typed, rows[i].want);
        ROW_DRAIN: drain_pulses();
        default: ;
      endcase
    end
  endtask

  task automatic random_moves(input int n, input bit far_ok);
    logic                ax;
    logic [TARGET_W-1:0] tgt;
    logic [TARGET_W-1:0] base;
    logic [TARGET_W-1:0] stp;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) == 0) hold_until_drained();
      ax = 1'($urandom);
      if (m_pulses_owed != 0) begin
        if ($urandom_range(99) < 8) send_item(FUNC_MOVE, ax, 16'($urandom), 1'b0, '0);
        else send_item(FUNC_TICK, ax, 16'($urandom), 1'b0, '0);
      end else if ($urandom_range(99) < 55) begin
        if (far_ok && $urandom_range(9) == 0) begin
          case ($urandom_range(2))
            0: tgt = '0;
            1: tgt = '1;
            default: tgt = 16'($urandom);
          endcase
        end else begin
          base = m_pos[ax][POS_W-1:FRAC_BITS];
          stp = 16'($urandom_range(3));
          if ($urandom_range(1) == 1) tgt = (base > 16'hFFFF - stp) ? 16'hFFFF : base + stp;
          else tgt = (base < stp) ? 16'h0000 : base - stp;
        end
        send_item(FUNC_MOVE, ax, tgt, 1'b0, '0);
      end else begin
        send_item(FUNC_TICK, ax, 16'($urandom), 1'b0, '0);
      end
    end
    drain_pulses();
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    stepper_res_t got;
    stepper_res_t want;
    if (!rst && out_valid && out_ready) begin
      got = {step_x, step_y, dir_x, dir_y, busy_res, accepted, pulse_count, new_position};
      if (expected_results.size() == 0) begin
        n_errors++;
        $display("%0t unexpected result: expected none got %0h", $time, got);
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        check_field("step_x", 32'(want.step_x), 32'(got.step_x));
        check_field("step_y", 32'(want.step_y), 32'(got.step_y));
        check_field("dir_x", 32'(want.dir_x), 32'(got.dir_x));
        check_field("dir_y", 32'(want.dir_y), 32'(got.dir_y));
        check_field("busy_res", 32'(want.busy), 32'(got.busy));
        check_field("accepted", 32'(want.taken), 32'(got.taken));
        check_field("pulse_count", 32'(want.pulses), 32'(got.pulses));
        check_field("new_position", 32'(want.pos), 32'(got.pos));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("two_axis_stepper_move_generator regression: fail");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    func = FUNC_TICK;
    axis = AXIS_X;
    target = '0;
    m_step_dist = STEP_DIST_RESET;
    m_high = PULSE_HIGH_RESET;
    m_period = PULSE_PERIOD_RESET;
    m_pos[AXIS_X] = '0;
    m_pos[AXIS_Y] = '0;
    m_dir[AXIS_X] = 1'b0;
    m_dir[AXIS_Y] = 1'b0;
    m_pulses_owed = '0;
    m_pulse_axis = AXIS_X;
    m_phase = '0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    play_rows(opening_rows);

    for (int ph = 0; ph < 6; ph++) begin
      snd_idle_pct = (ph < 2) ? 33 : (ph < 4) ? 76 : 0;
      rcv_idle_pct = (ph < 2) ? 76 : (ph < 4) ? 33 : 0;
      write_reg(REG_STEP_DIST, plan_step_dist[ph]);
      write_reg(REG_PULSE_HIGH, plan_high[ph]);
      write_reg(REG_PULSE_PERIOD, plan_period[ph]);
      random_moves(225, ph == 1);
    end

    play_rows(closing_rows);

    hold_until_drained();
    repeat (30) @(negedge clk);

    $display("covered %0d transfers: %0d moves taken, %0d refused, %0d ticks with a step high",
             n_items, n_taken, n_refused, n_step_high);
    $display("%0d results checked across six pulse settings and the corner rows, %0d mismatches",
             n_checked, n_errors);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("two_axis_stepper_move_generator regression: pass");
    end else begin
      $display("two_axis_stepper_move_generator regression: fail");
    end
    $finish;
  end

endmodule
